### design/ic3_pkg.sv
package ic3_pkg;

  // Fixed field widths
  localparam int OutBits     = 28;
  localparam int PixFieldBits = 8;
  localparam int KernelBits  = 48;
  localparam int CoeffStride = 16;
  localparam int WidthBits   = 11;
  localparam int HeightBits  = 16;

  // Configuration port
  localparam int AddrBits = 6;
  localparam int DataBits = 64;

  localparam logic [2:0] RegWidth        = 3'd0;
  localparam logic [2:0] RegHeight       = 3'd1;
  localparam logic [2:0] RegKernelTop    = 3'd2;
  localparam logic [2:0] RegKernelMiddle = 3'd3;
  localparam logic [2:0] RegKernelBottom = 3'd4;

  localparam logic [WidthBits-1:0]  WidthReset   = 11'd1024;
  localparam logic [HeightBits-1:0] HeightReset  = 16'd1024;
  localparam logic [KernelBits-1:0] KernelTopReset    = 48'd0;
  localparam logic [KernelBits-1:0] KernelMiddleReset = 48'd65536;
  localparam logic [KernelBits-1:0] KernelBottomReset = 48'd0;

  // Input word kinds
  localparam logic KindPixel = 1'b0;
  localparam logic KindFlush = 1'b1;

  // Depth of the queue between front and back
  localparam int QueueDepth = 4;

  typedef struct packed {
    logic                    kind;
    logic [PixFieldBits-1:0] pixel;
  } in_word_t;

  typedef struct packed {
    logic signed [OutBits-1:0] filtered;
    logic                      frame_end;
  } out_word_t;

  // Classification of one column step, front to back
  typedef struct packed {
    logic xlt;    // column inside the row
    logic x0;     // first column
    logic y1;     // row one or later
    logic y2;     // row two or later
    logic store;  // write the line stores
    logic emit;   // step yields an output
    logic last;   // final output of the frame
  } op_ctl_t;

endpackage

### design/ic3_regs.sv
module ic3_regs import ic3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AddrBits-1:0]   paddr,
  input  logic [DataBits-1:0]   pwdata,
  output logic [DataBits-1:0]   prdata,
  output logic                  pready,
  output logic [WidthBits-1:0]  width_o,
  output logic [HeightBits-1:0] height_o,
  output logic [2:0][KernelBits-1:0] kernel_o
);

  logic [WidthBits-1:0]  width_q;
  logic [HeightBits-1:0] height_q;
  logic [2:0][KernelBits-1:0] kernel_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[AddrBits-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WidthReset;
      height_q    <= HeightReset;
      kernel_q[0] <= KernelTopReset;
      kernel_q[1] <= KernelMiddleReset;
      kernel_q[2] <= KernelBottomReset;
    end else if (wr_en) begin
      case (idx)
        RegWidth:        width_q     <= pwdata[WidthBits-1:0];
        RegHeight:       height_q    <= pwdata[HeightBits-1:0];
        RegKernelTop:    kernel_q[0] <= pwdata[KernelBits-1:0];
        RegKernelMiddle: kernel_q[1] <= pwdata[KernelBits-1:0];
        RegKernelBottom: kernel_q[2] <= pwdata[KernelBits-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      RegWidth:        prdata = DataBits'(width_q);
      RegHeight:       prdata = DataBits'(height_q);
      RegKernelTop:    prdata = DataBits'(kernel_q[0]);
      RegKernelMiddle: prdata = DataBits'(kernel_q[1]);
      RegKernelBottom: prdata = DataBits'(kernel_q[2]);
      default:         prdata = '0;
    endcase
  end

  assign width_o  = width_q;
  assign height_o = height_q;
  assign kernel_o = kernel_q;

endmodule

### design/ic3_front.sv
module ic3_front import ic3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  in_word_t                      in_data_i,
  input  logic [WidthBits-1:0]          width_i,
  input  logic [HeightBits-1:0]         height_i,
  input  logic                          full_i,
  output logic                          push_o,
  output op_ctl_t                       ctl_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  addr_o,
  output logic [PIXEL_BITS-1:0]         pix_o
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);

  logic [HeightBits-1:0] row_q, row_d;
  logic [CW-1:0]         col_q, col_d;
  logic [CW-1:0]         flush_q, flush_d;
  logic                  flushing_q, flushing_d;

  logic [CW-1:0]         w_eff;
  logic [HeightBits-1:0] h_eff;
  logic                  accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // Effective geometry
  always_comb begin
    if (width_i == '0) begin
      w_eff = CW'(1);
    end else if (32'(width_i) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_i);
    end
    h_eff = (height_i == '0) ? HeightBits'(1) : height_i;
  end

  // Position tracking and step classification
  always_comb begin
    logic [HeightBits-1:0] r;
    logic [CW-1:0]         c;
    logic [CW-1:0]         x;
    logic [HeightBits-1:0] y;
    logic                  go;
    logic                  store;
    logic                  last;
    row_d      = row_q;
    col_d      = col_q;
    flush_d    = flush_q;
    flushing_d = flushing_q;
    r     = row_q;
    c     = col_q;
    x     = '0;
    y     = row_q;
    go    = 1'b0;
    store = 1'b0;
    last  = 1'b0;
    if (accept) begin
      if (!flushing_q) begin
        if (in_data_i.kind == KindPixel) begin
          if (r < h_eff && c >= w_eff) begin
            c = '0;
            r = r + HeightBits'(1);
          end
          if (r >= h_eff) begin
            flushing_d = 1'b1;
            flush_d    = '0;
          end else begin
            go    = 1'b1;
            store = 1'b1;
            x     = c;
            y     = r;
            c     = c + CW'(1);
            if (c >= w_eff) begin
              c = '0;
              r = r + HeightBits'(1);
              if (r >= h_eff) begin
                flushing_d = 1'b1;
                flush_d    = '0;
              end
            end
          end
          row_d = r;
          col_d = c;
        end
      end else if (in_data_i.kind == KindFlush) begin
        go   = 1'b1;
        x    = (flush_q >= w_eff) ? w_eff : flush_q;
        last = (x == w_eff);
        if (last) begin
          flushing_d = 1'b0;
          flush_d    = '0;
          row_d      = '0;
          col_d      = '0;
        end else begin
          flush_d = flush_q + CW'(1);
        end
      end
    end
    push_o      = go;
    ctl_o.xlt   = (x < w_eff);
    ctl_o.x0    = (x == '0);
    ctl_o.y1    = (y >= HeightBits'(1));
    ctl_o.y2    = (y >= HeightBits'(2));
    ctl_o.store = store;
    ctl_o.last  = last;
    ctl_o.emit  = ctl_o.xlt ? (ctl_o.x0 ? ctl_o.y2 : ctl_o.y1) : ctl_o.y1;
    addr_o      = AW'(x);
    pix_o       = store ? PIXEL_BITS'(in_data_i.pixel) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      flush_q    <= '0;
      flushing_q <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      flush_q    <= flush_d;
      flushing_q <= flushing_d;
    end
  end

endmodule

### design/ic3_queue.sv
module ic3_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] head_q, tail_q;
  logic [NW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == NW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[head_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[tail_q] <= data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        tail_q <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);
      end
      if (do_pop) begin
        head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + NW'(1);
        2'b01:   count_q <= count_q - NW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### design/ic3_back.sv
module ic3_back import ic3_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int KERNEL_ROWS = 3,
  parameter int KERNEL_COLS = 3,
  parameter int PIXEL_BITS  = 8,
  parameter int COEFF_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  op_ctl_t                       q_ctl_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  q_addr_i,
  input  logic [PIXEL_BITS-1:0]         q_pix_i,
  input  logic [2:0][KernelBits-1:0]    kernel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output out_word_t                     out_data_o
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int PW     = PIXEL_BITS + COEFF_BITS + 1;
  localparam int RowOff = 2 + KERNEL_ROWS / 2 - KERNEL_ROWS;
  localparam int ColOff = 2 + KERNEL_COLS / 2 - KERNEL_COLS;

  // Line stores: row y-2 and row y-1
  logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] rd_old_q, rd_new_q;

  // Stage 1: line store read done, window update
  logic                  s1_v_q;
  op_ctl_t               s1_ctl_q;
  logic [AW-1:0]         s1_addr_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic                  s1_ready, s1_adv, wr_en;

  logic [2:0][2:0][PIXEL_BITS-1:0] win_q, win_new, snap;
  logic [PIXEL_BITS-1:0] a, b;

  // Stage 2: products
  logic                      s2_v_q, s2_last_q, s2_ready, s2_load;
  logic signed [OutBits-1:0] prod_q [3][3];
  logic signed [COEFF_BITS-1:0] coef [3][3];
  logic signed [PW-1:0]      prod [3][3];

  // Stage 3: row sums
  logic                      s3_v_q, s3_last_q, s3_ready;
  logic signed [OutBits-1:0] rsum_q [3];

  // Output register
  logic      out_v_q, out_ready;
  out_word_t out_q;

  // Handshake chain
  assign out_ready = !out_v_q || !out_stall_i;
  assign s3_ready  = !s3_v_q || out_ready;
  assign s2_ready  = !s2_v_q || s3_ready;
  assign s1_adv    = s1_v_q && (!s1_ctl_q.emit || s2_ready);
  assign s1_ready  = !s1_v_q || s1_adv;
  assign q_pop_o   = q_valid_i && s1_ready;
  assign s2_load   = s1_adv && s1_ctl_q.emit;
  assign wr_en     = s1_adv && s1_ctl_q.store;

  assign a = s1_ctl_q.y2 ? rd_old_q : '0;
  assign b = s1_ctl_q.y1 ? rd_new_q : '0;

  // Line stores, read with write bypass for one-pixel rows
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      older_mem[s1_addr_q] <= b;
      newer_mem[s1_addr_q] <= s1_pix_q;
    end
    if (q_pop_o) begin
      if (wr_en && s1_addr_q == q_addr_i) begin
        rd_old_q <= b;
        rd_new_q <= s1_pix_q;
      end else begin
        rd_old_q <= older_mem[q_addr_i];
        rd_new_q <= newer_mem[q_addr_i];
      end
    end
  end

  // Stage 1 word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_ctl_q  <= q_ctl_i;
      s1_addr_q <= q_addr_i;
      s1_pix_q  <= q_pix_i;
    end
  end

  // Window shift; first column of a row also restarts the window
  always_comb begin
    logic [2:0][PIXEL_BITS-1:0] col;
    col = '0;
    if (s1_ctl_q.xlt && !s1_ctl_q.x0) begin
      col[0] = a;
      col[1] = b;
      col[2] = s1_pix_q;
    end
    for (int r = 0; r < 3; r++) begin
      snap[r][0] = win_q[r][1];
      snap[r][1] = win_q[r][2];
      snap[r][2] = col[r];
    end
    win_new = snap;
    if (s1_ctl_q.xlt && s1_ctl_q.x0) begin
      win_new    = '0;
      win_new[0][2] = a;
      win_new[1][2] = b;
      win_new[2][2] = s1_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q <= win_new;
    end
  end

  // Coefficients placed in the 3x3 neighborhood
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r][c] = '0;
        if (r >= RowOff && r < RowOff + KERNEL_ROWS &&
            c >= ColOff && c < ColOff + KERNEL_COLS) begin
          coef[r][c] = kernel_i[r - RowOff][CoeffStride * (c - ColOff) +: COEFF_BITS];
        end
      end
    end
  end

  // Nine parallel multiplies
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] = $signed({1'b0, snap[r][c]}) * coef[r][c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= s2_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_last_q <= s1_ctl_q.last;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= OutBits'(prod[r][c]);
        end
      end
    end
  end

  // Row sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_ready) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_v_q) begin
      s3_last_q <= s2_last_q;
      for (int r = 0; r < 3; r++) begin
        rsum_q[r] <= prod_q[r][0] + prod_q[r][1] + prod_q[r][2];
      end
    end
  end

  // Final sum into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s3_v_q) begin
      out_q.filtered  <= rsum_q[0] + rsum_q[1] + rsum_q[2];
      out_q.frame_end <= s3_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

### design/image_convolution_3x3.sv
// Channel  Dir  Handshake                Word
// in       in   in_valid_i / in_stall_o   in_word_t  {kind, pixel}
// out      out  out_valid_o / out_stall_i out_word_t {filtered, frame_end}
// cfg      in   psel/penable/pwrite       64-bit registers at 8*index
//
// One word per cycle sustained while the output is not stalled; the line stores
// have one read and one write port each; a pixel step uses each once, a flush
// step only reads. A result passes through the queue and the stage 1, product,
// row-sum and output registers. Reset clears position counters, the window and
// all valid bits; line stores are not cleared. A stalled output backs up through
// the pipeline into the four-entry queue; the input stalls only when it is full.
module image_convolution_3x3 import ic3_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int KERNEL_ROWS = 3,
  parameter int KERNEL_COLS = 3,
  parameter int PIXEL_BITS  = 8,
  parameter int COEFF_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int QW = $bits(op_ctl_t) + AW + PIXEL_BITS;

  logic [WidthBits-1:0]       width;
  logic [HeightBits-1:0]      height;
  logic [2:0][KernelBits-1:0] kernel;

  logic                  push, full, q_valid, q_pop;
  op_ctl_t               f_ctl, b_ctl;
  logic [AW-1:0]         f_addr, b_addr;
  logic [PIXEL_BITS-1:0] f_pix, b_pix;

  ic3_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .width_o  (width),
    .height_o (height),
    .kernel_o (kernel)
  );

  ic3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .width_i    (width),
    .height_i   (height),
    .full_i     (full),
    .push_o     (push),
    .ctl_o      (f_ctl),
    .addr_o     (f_addr),
    .pix_o      (f_pix)
  );

  ic3_queue #(
    .W     (QW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_ctl, f_addr, f_pix}),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  ({b_ctl, b_addr, b_pix})
  );

  ic3_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .KERNEL_ROWS (KERNEL_ROWS),
    .KERNEL_COLS (KERNEL_COLS),
    .PIXEL_BITS  (PIXEL_BITS),
    .COEFF_BITS  (COEFF_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_ctl_i     (b_ctl),
    .q_addr_i    (b_addr),
    .q_pix_i     (b_pix),
    .kernel_i    (kernel),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### test/tb.sv
module tb;
  import ic3_pkg::*;

  localparam int LineLen   = 1024;  // deepest line store
  localparam int MaxReport = 60;    // mismatch reports before going quiet

  // Predicts filtered words from accepted input words and checks the output stream
  class conv_scoreboard;
    logic [WidthBits-1:0]  width_reg;
    logic [HeightBits-1:0] height_reg;
    logic [KernelBits-1:0] kern [3];
    logic [7:0]            older [LineLen];
    logic [7:0]            newer [LineLen];
    logic [7:0]            win [3][3];
    int                    row_cnt;
    int                    col_cnt;
    int                    flush_cnt;
    bit                    flushing;
    out_word_t             expected_pixels [$];
    int                    mismatches;

    function new();
      width_reg  = WidthReset;
      height_reg = HeightReset;
      kern[0]    = KernelTopReset;
      kern[1]    = KernelMiddleReset;
      kern[2]    = KernelBottomReset;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) win[r][c] = 8'd0;
      end
      row_cnt    = 0;
      col_cnt    = 0;
      flush_cnt  = 0;
      flushing   = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [DataBits-1:0] val);
      case (idx)
        RegWidth: begin
          width_reg = val[WidthBits-1:0];
        end
        RegHeight: begin
          height_reg = val[HeightBits-1:0];
        end
        RegKernelTop, RegKernelMiddle, RegKernelBottom: begin
          kern[idx - RegKernelTop] = val[KernelBits-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // Kernel applied unflipped over the 3x3 window, wrapped to 28 bits
    function logic [OutBits-1:0] kernel_dot();
      longint acc;
      logic signed [15:0] coef;
      acc = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          coef = kern[r][CoeffStride*c +: 16];
          acc += longint'(win[r][c]) * longint'(coef);
        end
      end
      return acc[OutBits-1:0];
    endfunction

    function void shift_column(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = a;
      win[1][2] = b;
      win[2][2] = c;
    endfunction

    // One column position x in 0..w of row y; returns 1 when acc holds a result
    function bit step_column(int y, int x, int w, logic [7:0] pix, bit store,
                             output logic [OutBits-1:0] acc);
      logic [7:0] up2;
      logic [7:0] up1;
      bit hit;
      hit = 1'b0;
      acc = '0;
      if (x < w) begin
        up2 = (y >= 2) ? older[x] : 8'd0;
        up1 = (y >= 1) ? newer[x] : 8'd0;
        if (x == 0) begin
          // row start: close the previous row's last column first
          if (y >= 2) begin
            shift_column(8'd0, 8'd0, 8'd0);
            acc = kernel_dot();
            hit = 1'b1;
          end
          for (int r = 0; r < 3; r++) begin
            win[r][0] = 8'd0;
            win[r][1] = 8'd0;
          end
          win[0][2] = up2;
          win[1][2] = up1;
          win[2][2] = pix;
        end else begin
          shift_column(up2, up1, pix);
          if (y >= 1) begin
            acc = kernel_dot();
            hit = 1'b1;
          end
        end
        if (store) begin
          older[x] = up1;
          newer[x] = pix;
        end
      end else begin
        // past the row end: right-hand zero padding
        shift_column(8'd0, 8'd0, 8'd0);
        if (y >= 1) begin
          acc = kernel_dot();
          hit = 1'b1;
        end
      end
      return hit;
    endfunction

    function void accept_word(in_word_t wd);
      int w;
      int h;
      int x;
      bit last;
      bit hit;
      logic [OutBits-1:0] acc;
      out_word_t want;
      w = (width_reg == 0) ? 1 : ((width_reg > LineLen) ? LineLen : int'(width_reg));
      h = (height_reg == 0) ? 1 : int'(height_reg);
      if (!flushing) begin
        // flush ticks inside the frame are dropped
        if (wd.kind != KindPixel) return;
        if (row_cnt < h && col_cnt >= w) begin
          col_cnt = 0;
          row_cnt++;
        end
        if (row_cnt >= h) begin
          flushing  = 1'b1;
          flush_cnt = 0;
          return;
        end
        hit = step_column(row_cnt, col_cnt, w, wd.pixel, 1'b1, acc);
        col_cnt++;
        if (col_cnt >= w) begin
          col_cnt = 0;
          row_cnt++;
          if (row_cnt >= h) begin
            flushing  = 1'b1;
            flush_cnt = 0;
          end
        end
        last = 1'b0;
      end else begin
        // pixels while draining are dropped
        if (wd.kind != KindFlush) return;
        x    = (flush_cnt >= w) ? w : flush_cnt;
        last = (x == w);
        hit  = step_column(row_cnt, x, w, 8'd0, 1'b0, acc);
        if (last) begin
          flushing  = 1'b0;
          flush_cnt = 0;
          row_cnt   = 0;
          col_cnt   = 0;
        end else begin
          flush_cnt++;
        end
      end
      if (hit) begin
        want.filtered  = acc;
        want.frame_end = last;
        expected_pixels.push_back(want);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReport)
          $error("unexpected word: filtered %0d frame_end %0b", got.filtered, got.frame_end);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.filtered !== want.filtered) begin
        mismatches++;
        if (mismatches <= MaxReport)
          $error("filtered: expected %0d, actual %0d", want.filtered, got.filtered);
      end
      if (got.frame_end !== want.frame_end) begin
        mismatches++;
        if (mismatches <= MaxReport)
          $error("frame_end: expected %0b, actual %0b", want.frame_end, got.frame_end);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_word_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [AddrBits-1:0] paddr       = '0;
  logic [DataBits-1:0] pwdata      = '0;
  logic [DataBits-1:0] prdata;
  logic                pready;

  conv_scoreboard sb;
  bit             quiet        = 1'b0;  // no idling on either side
  int             rx_hold_left = 0;     // long receiver hold-off request
  int             words_sent   = 0;

  image_convolution_3x3 DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watch both channels at the edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.accept_word(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(out_data_o);
  end

  // Output side stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        out_stall_i <= 1'b1;
        rx_hold_left--;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 7);
      end
    end
  end

  function automatic in_word_t word_of(logic kind, logic [7:0] pix);
    in_word_t wd;
    wd.kind  = kind;
    wd.pixel = pix;
    return wd;
  endfunction

  function automatic logic [7:0] rand_pixel();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'd0;
    if (roll < 20) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [KernelBits-1:0] pick_kernel_row();
    logic [KernelBits-1:0] row;
    int roll;
    for (int j = 0; j < 3; j++) begin
      roll = $urandom_range(99);
      if (roll < 12)      row[16*j +: 16] = 16'h8000;
      else if (roll < 24) row[16*j +: 16] = 16'h7FFF;
      else if (roll < 40) row[16*j +: 16] = 16'($urandom_range(7)) - 16'd3;
      else                row[16*j +: 16] = 16'($urandom);
    end
    return row;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [DataBits-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one word and hold it until taken
  task automatic send_word(in_word_t wd);
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= wd;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Pause input until every predicted word is out, then let the pipe empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // A well-formed frame plus a few dropped words; cut leaves the drain unfinished
  task automatic run_frame(int cols, int rows, bit cut);
    int ticks;
    ticks = cut ? $urandom_range(cols) : cols + 1;
    for (int i = 0; i < cols * rows; i++) begin
      if ($urandom_range(99) < 3) send_word(word_of(KindFlush, rand_pixel()));
      send_word(word_of(KindPixel, rand_pixel()));
    end
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(99) < 3) send_word(word_of(KindPixel, rand_pixel()));
      send_word(word_of(KindFlush, rand_pixel()));
    end
    words_sent += cols * rows + ticks;
  endtask

  initial begin
    #2400000;
    $display("** image_convolution_3x3: FAILED **");
    $finish;
  end

  initial begin
    logic [7:0]            dir_pix [9];
    logic [WidthBits-1:0]  w_reg;
    logic [HeightBits-1:0] h_reg;
    int                    cols;
    int                    rows;
    sb = new();
    dir_pix = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd1};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Zero geometry reads as a 1x1 frame; stray words on both sides
    reg_write(RegWidth, '0);
    reg_write(RegHeight, '0);
    reg_write(RegKernelTop, 64'h7FFF_7FFF_7FFF);
    reg_write(RegKernelMiddle, 64'h7FFF_7FFF_7FFF);
    reg_write(RegKernelBottom, 64'h7FFF_7FFF_7FFF);
    send_word(word_of(KindPixel, 8'd255));
    send_word(word_of(KindPixel, 8'd0));
    send_word(word_of(KindFlush, 8'd0));
    send_word(word_of(KindFlush, 8'd0));
    send_word(word_of(KindFlush, 8'd0));
    settle();

    // 3x3 frame with extreme coefficients and pixels
    reg_write(RegWidth, 64'd3);
    reg_write(RegHeight, 64'd3);
    reg_write(RegKernelTop, 64'h0001_8000_7FFF);
    reg_write(RegKernelMiddle, 64'h8000_7FFF_FFFF);
    reg_write(RegKernelBottom, 64'h8000_8000_8000);
    foreach (dir_pix[i]) send_word(word_of(KindPixel, dir_pix[i]));
    repeat (4) send_word(word_of(KindFlush, 8'd0));
    settle();

    // Tallest frame, cut short by shrinking the geometry mid-frame
    reg_write(RegHeight, 64'd65535);
    for (int i = 0; i < 4; i++) send_word(word_of(KindPixel, rand_pixel()));
    settle();
    reg_write(RegWidth, 64'd1);
    send_word(word_of(KindPixel, 8'd255));
    settle();
    reg_write(RegHeight, 64'd2);
    reg_write(RegWidth, 64'd3);
    send_word(word_of(KindPixel, 8'd77));
    send_word(word_of(KindFlush, 8'd0));
    send_word(word_of(KindFlush, 8'd0));
    settle();
    // flush count now past the width: the next tick closes the frame
    reg_write(RegWidth, 64'd1);
    send_word(word_of(KindFlush, 8'd0));
    settle();

    // Oversized width clamps to a full line; fills both line stores.
    // Two ticks drain only if the row wrapped at the clamped width.
    reg_write(RegWidth, 64'd2047);
    reg_write(RegHeight, 64'd1);
    reg_write(RegKernelMiddle, pick_kernel_row());
    for (int i = 0; i < LineLen; i++) send_word(word_of(KindPixel, rand_pixel()));
    repeat (2) send_word(word_of(KindFlush, 8'd0));
    settle();
    // narrow the row so the next tick ends the drain
    reg_write(RegWidth, 64'd1);
    send_word(word_of(KindFlush, 8'd0));
    settle();
    words_sent += LineLen + 3;

    // Receiver holds off while the sender keeps going
    reg_write(RegWidth, 64'd12);
    reg_write(RegHeight, 64'd8);
    reg_write(RegKernelTop, pick_kernel_row());
    reg_write(RegKernelBottom, pick_kernel_row());
    rx_hold_left = 80;
    run_frame(12, 8, 1'b0);
    settle();

    // Back-to-back stretch with no idling anywhere
    quiet = 1'b1;
    reg_write(RegWidth, 64'd16);
    reg_write(RegHeight, 64'd6);
    run_frame(16, 6, 1'b0);
    settle();
    quiet = 1'b0;

    // Random geometry, kernels and frame runs
    while (words_sent < 1450) begin
      w_reg = ($urandom_range(19) == 0) ? '0 :
              ($urandom_range(6) == 0) ? 11'($urandom_range(13, 40)) :
              11'($urandom_range(1, 12));
      h_reg = ($urandom_range(19) == 0) ? '0 : 16'($urandom_range(1, 8));
      cols  = (w_reg == 0) ? 1 : int'(w_reg);
      rows  = (h_reg == 0) ? 1 : int'(h_reg);
      reg_write(RegWidth, 64'(w_reg));
      reg_write(RegHeight, 64'(h_reg));
      if ($urandom_range(1) == 1) begin
        reg_write(RegKernelTop, pick_kernel_row());
        reg_write(RegKernelMiddle, pick_kernel_row());
        reg_write(RegKernelBottom, pick_kernel_row());
      end
      repeat ($urandom_range(1, 3)) run_frame(cols, rows, $urandom_range(9) == 0);
      settle();
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("** image_convolution_3x3: PASSED **");
    end else begin
      $display("** image_convolution_3x3: FAILED **");
    end
    $finish;
  end

endmodule

### image_convolution_3x3.f
design/ic3_pkg.sv
design/ic3_regs.sv
design/ic3_front.sv
design/ic3_queue.sv
design/ic3_back.sv
design/image_convolution_3x3.sv
test/tb.sv
